/* design/cob_pkg.sv */
// Shared types, widths and saturation helpers for the contact basis pipeline.
`timescale 1ns / 1ps

package cob_pkg;

	localparam int COMP_W   = 16;
	localparam int PROD_W   = 32;
	localparam int DIFF_W   = 33;
	localparam int SQ_STEPS = 24;
	localparam int ROOT_W   = 24;
	localparam int REM_W    = 26;
	localparam int D_PAIRS  = 16;

	typedef logic signed [COMP_W-1:0] comp_t;
	typedef logic [COMP_W-1:0] mag_t;

	localparam comp_t SAT_MAX = 16'sh7FFF;
	localparam comp_t SAT_MIN = 16'sh8000;
	localparam logic [DIFF_W-1:0] POS_LIMIT = 33'd32767;
	localparam logic [DIFF_W-1:0] NEG_LIMIT = 33'd32768;

	// Per-item context that rides along with the arithmetic.
	typedef struct packed {
		comp_t x;
		comp_t y;
		comp_t z;
		logic  first;
		logic  degen;
		mag_t  mag_p;
		mag_t  mag_q;
		logic  neg_p;
		logic  neg_q;
	} ctx_t;

	typedef struct packed {
		comp_t row0_x;
		comp_t row0_y;
		comp_t row0_z;
		comp_t tangent_a_x;
		comp_t tangent_a_y;
		comp_t tangent_a_z;
		comp_t tangent_b_x;
		comp_t tangent_b_y;
		comp_t tangent_b_z;
		logic  degenerate;
	} res_t;

	function automatic mag_t mag16(comp_t v);
		mag_t m;
		m = v[COMP_W-1] ? mag_t'(-v) : mag_t'(v);
		return m;
	endfunction

	// Apply the sign to a magnitude and clamp to the 16-bit signed range.
	function automatic comp_t sat_mag(logic [DIFF_W-1:0] q, logic neg);
		comp_t r;
		if (neg) begin
			r = (q > NEG_LIMIT) ? SAT_MIN : comp_t'(-q[COMP_W-1:0]);
		end else begin
			r = (q > POS_LIMIT) ? SAT_MAX : comp_t'(q[COMP_W-1:0]);
		end
		return r;
	endfunction

endpackage

/* design/cob_in_if.sv */
// Normal-vector input channel.
`timescale 1ns / 1ps

interface cob_in_if;
	logic          valid;
	logic          ready;
	cob_pkg::comp_t normal_x;
	cob_pkg::comp_t normal_y;
	cob_pkg::comp_t normal_z;

	modport source(output valid, output normal_x, output normal_y, output normal_z,
		input ready);
	modport sink(input valid, input normal_x, input normal_y, input normal_z,
		output ready);
endinterface

/* design/cob_out_if.sv */
// Basis output channel.
`timescale 1ns / 1ps

interface cob_out_if;
	logic          valid;
	logic          ready;
	cob_pkg::comp_t row0_x;
	cob_pkg::comp_t row0_y;
	cob_pkg::comp_t row0_z;
	cob_pkg::comp_t tangent_a_x;
	cob_pkg::comp_t tangent_a_y;
	cob_pkg::comp_t tangent_a_z;
	cob_pkg::comp_t tangent_b_x;
	cob_pkg::comp_t tangent_b_y;
	cob_pkg::comp_t tangent_b_z;
	logic          degenerate;

	modport source(output valid, output row0_x, output row0_y, output row0_z,
		output tangent_a_x, output tangent_a_y, output tangent_a_z,
		output tangent_b_x, output tangent_b_y, output tangent_b_z,
		output degenerate, input ready);
	modport sink(input valid, input row0_x, input row0_y, input row0_z,
		input tangent_a_x, input tangent_a_y, input tangent_a_z,
		input tangent_b_x, input tangent_b_y, input tangent_b_z,
		input degenerate, output ready);
endinterface

/* design/contact_orthonormal_basis_core.sv */
// Contact basis pipeline: unit normal in, normal plus two orthonormal tangents out.
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+------------------------------------------------
//   nrm     | in  | valid / ready | normal_x, normal_y, normal_z (Q1.15)
//   basis   | out | valid / ready | row0_*, tangent_a_*, tangent_b_*, degenerate
//
// One transaction per cycle sustained while the output is not stalled. 34 + FRAC_BITS
// register stages (49 at the default): 3 setup, 24 square-root digit, 1 numerator,
// FRAC_BITS + 2 restoring-division stages, then tangent, multiply, difference and rounding.
// arst_n clears the stage valid bits and the skid valid bit; payload is not reset.
// A stalled output parks one result in the skid register and the whole pipeline
// holds until it drains, so nrm.ready is a flop output.
`timescale 1ns / 1ps

module contact_orthonormal_basis_core #(
	parameter int FRAC_BITS = 15
) (
	input  logic         clk,
	input  logic         arst_n,
	cob_in_if.sink       nrm,
	cob_out_if.source    basis
);

	localparam int N_W    = FRAC_BITS + 24;
	localparam int DIV_W  = (N_W + 1 > 40) ? N_W + 1 : 40;
	localparam int N_SH   = FRAC_BITS + 8;
	localparam int Q_W    = FRAC_BITS + 2;
	localparam logic [cob_pkg::DIFF_W-1:0] RND_HALF =
		cob_pkg::DIFF_W'(1) << (FRAC_BITS - 1);

	logic en;
	logic skid_valid_q;
	cob_pkg::res_t skid_q;

	assign en = !skid_valid_q;
	assign nrm.ready = en;

	// ---------------- stage 1: magnitudes and branch select
	logic v_s1;
	cob_pkg::ctx_t ctx_s1;
	cob_pkg::comp_t a_s1;
	cob_pkg::mag_t ax_in, ay_in;
	logic first_in;

	assign ax_in = cob_pkg::mag16(nrm.normal_x);
	assign ay_in = cob_pkg::mag16(nrm.normal_y);
	assign first_in = ax_in > ay_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= nrm.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1.x     <= nrm.normal_x;
			ctx_s1.y     <= nrm.normal_y;
			ctx_s1.z     <= nrm.normal_z;
			ctx_s1.first <= first_in;
			ctx_s1.degen <= 1'b0;
			ctx_s1.mag_p <= cob_pkg::mag16(nrm.normal_z);
			ctx_s1.mag_q <= first_in ? ax_in : ay_in;
			// first branch: t = (z, 0, -x); second: t = (0, -z, y)
			ctx_s1.neg_p <= first_in ? nrm.normal_z[cob_pkg::COMP_W-1]
				: (nrm.normal_z != '0 && !nrm.normal_z[cob_pkg::COMP_W-1]);
			ctx_s1.neg_q <= first_in
				? (nrm.normal_x != '0 && !nrm.normal_x[cob_pkg::COMP_W-1])
				: nrm.normal_y[cob_pkg::COMP_W-1];
			a_s1 <= first_in ? nrm.normal_x : nrm.normal_y;
		end
	end

	// ---------------- stage 2: squares
	logic v_s2;
	cob_pkg::ctx_t ctx_s2;
	logic [cob_pkg::PROD_W-1:0] aa_s2, zz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s2 <= ctx_s1;
			aa_s2  <= cob_pkg::PROD_W'(a_s1) * cob_pkg::PROD_W'(a_s1);
			zz_s2  <= cob_pkg::PROD_W'(ctx_s1.z) * cob_pkg::PROD_W'(ctx_s1.z);
		end
	end

	// ---------------- stage 3: denominator
	logic v_s3;
	cob_pkg::ctx_t ctx_s3, ctx_deg;
	logic [cob_pkg::PROD_W-1:0] d_s3, d_sum;

	assign d_sum = aa_s2 + zz_s2;

	always_comb begin
		ctx_deg       = ctx_s2;
		ctx_deg.degen = (d_sum == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s3 <= ctx_deg;
			d_s3   <= d_sum;
		end
	end

	// ---------------- stages 4..27: square root of d * 2^16, one digit per stage
	logic                       sq_v_s    [0:cob_pkg::SQ_STEPS-1];
	cob_pkg::ctx_t              sq_ctx_s  [0:cob_pkg::SQ_STEPS-1];
	logic [cob_pkg::PROD_W-1:0] sq_d_s    [0:cob_pkg::SQ_STEPS-1];
	logic [cob_pkg::ROOT_W-1:0] sq_root_s [0:cob_pkg::SQ_STEPS-1];
	logic [cob_pkg::REM_W-1:0]  sq_rem_s  [0:cob_pkg::SQ_STEPS-1];

	for (genvar k = 0; k < cob_pkg::SQ_STEPS; k++) begin : g_sqrt
		logic                       v_in;
		cob_pkg::ctx_t              ctx_in;
		logic [cob_pkg::PROD_W-1:0] d_in;
		logic [cob_pkg::ROOT_W-1:0] root_in;
		logic [cob_pkg::REM_W-1:0]  rem_in;
		logic [1:0]                 pair;
		logic [cob_pkg::REM_W+1:0]  rem_sh, trial;
		logic                       ge;

		if (k == 0) begin : g_head
			assign v_in    = v_s3;
			assign ctx_in  = ctx_s3;
			assign d_in    = d_s3;
			assign root_in = '0;
			assign rem_in  = '0;
		end else begin : g_body
			assign v_in    = sq_v_s[k-1];
			assign ctx_in  = sq_ctx_s[k-1];
			assign d_in    = sq_d_s[k-1];
			assign root_in = sq_root_s[k-1];
			assign rem_in  = sq_rem_s[k-1];
		end

		// low 16 bits of the radicand are the appended zero fraction
		if (k < cob_pkg::D_PAIRS) begin : g_pair
			assign pair = d_in[cob_pkg::PROD_W-1-2*k -: 2];
		end else begin : g_zero
			assign pair = 2'b00;
		end

		assign rem_sh = {rem_in, pair};
		assign trial  = {{(cob_pkg::REM_W - cob_pkg::ROOT_W){1'b0}}, root_in, 2'b01};
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k] <= 1'b0;
			end else if (en) begin
				sq_v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_ctx_s[k]  <= ctx_in;
				sq_d_s[k]    <= d_in;
				sq_root_s[k] <= {root_in[cob_pkg::ROOT_W-2:0], ge};
				sq_rem_s[k]  <= ge ? cob_pkg::REM_W'(rem_sh - trial)
					: cob_pkg::REM_W'(rem_sh);
			end
		end
	end

	// ---------------- stage 28: rounded numerators
	logic v_s28;
	cob_pkg::ctx_t ctx_s28;
	logic [cob_pkg::ROOT_W-1:0] s_s28;
	logic [DIV_W-1:0] num_p_s28, num_q_s28;
	logic [cob_pkg::ROOT_W-1:0] s_root;

	assign s_root = sq_root_s[cob_pkg::SQ_STEPS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s28 <= 1'b0;
		end else if (en) begin
			v_s28 <= sq_v_s[cob_pkg::SQ_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s28   <= sq_ctx_s[cob_pkg::SQ_STEPS-1];
			s_s28     <= s_root;
			num_p_s28 <= (DIV_W'(sq_ctx_s[cob_pkg::SQ_STEPS-1].mag_p) << N_SH)
				+ DIV_W'(s_root >> 1);
			num_q_s28 <= (DIV_W'(sq_ctx_s[cob_pkg::SQ_STEPS-1].mag_q) << N_SH)
				+ DIV_W'(s_root >> 1);
		end
	end

	// ---------------- restoring division, one quotient bit per stage
	// A set top quotient bit means the magnitude is far past the 16-bit range.
	logic                       dv_v_s    [0:Q_W-1];
	cob_pkg::ctx_t              dv_ctx_s  [0:Q_W-1];
	logic [cob_pkg::ROOT_W-1:0] dv_den_s  [0:Q_W-1];
	logic [DIV_W-1:0]           dv_rp_s   [0:Q_W-1];
	logic [DIV_W-1:0]           dv_rq_s   [0:Q_W-1];
	logic [Q_W-1:0]             dv_qp_s   [0:Q_W-1];
	logic [Q_W-1:0]             dv_qq_s   [0:Q_W-1];

	for (genvar j = 0; j < Q_W; j++) begin : g_div
		localparam int SH = Q_W - 1 - j;
		logic                       v_in;
		cob_pkg::ctx_t              ctx_in;
		logic [cob_pkg::ROOT_W-1:0] den_in;
		logic [DIV_W-1:0]           rp_in, rq_in, trial;
		logic [Q_W-1:0]             qp_in, qq_in;
		logic                       ge_p, ge_q;

		if (j == 0) begin : g_head
			assign v_in   = v_s28;
			assign ctx_in = ctx_s28;
			assign den_in = s_s28;
			assign rp_in  = num_p_s28;
			assign rq_in  = num_q_s28;
			assign qp_in  = '0;
			assign qq_in  = '0;
		end else begin : g_body
			assign v_in   = dv_v_s[j-1];
			assign ctx_in = dv_ctx_s[j-1];
			assign den_in = dv_den_s[j-1];
			assign rp_in  = dv_rp_s[j-1];
			assign rq_in  = dv_rq_s[j-1];
			assign qp_in  = dv_qp_s[j-1];
			assign qq_in  = dv_qq_s[j-1];
		end

		assign trial = DIV_W'(den_in) << SH;
		assign ge_p  = rp_in >= trial;
		assign ge_q  = rq_in >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j] <= 1'b0;
			end else if (en) begin
				dv_v_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_ctx_s[j] <= ctx_in;
				dv_den_s[j] <= den_in;
				dv_rp_s[j]  <= ge_p ? rp_in - trial : rp_in;
				dv_rq_s[j]  <= ge_q ? rq_in - trial : rq_in;
				dv_qp_s[j]  <= {qp_in[Q_W-2:0], ge_p};
				dv_qq_s[j]  <= {qq_in[Q_W-2:0], ge_q};
			end
		end
	end

	// ---------------- stage 46: first tangent
	logic v_s46;
	cob_pkg::ctx_t ctx_s46;
	cob_pkg::comp_t tx_s46, ty_s46, tz_s46;
	cob_pkg::comp_t tp, tq;
	cob_pkg::ctx_t ctx_dv;

	assign ctx_dv = dv_ctx_s[Q_W-1];
	assign tp = cob_pkg::sat_mag(cob_pkg::DIFF_W'(dv_qp_s[Q_W-1]), ctx_dv.neg_p);
	assign tq = cob_pkg::sat_mag(cob_pkg::DIFF_W'(dv_qq_s[Q_W-1]), ctx_dv.neg_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s46 <= 1'b0;
		end else if (en) begin
			v_s46 <= dv_v_s[Q_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s46 <= ctx_dv;
			tx_s46  <= (ctx_dv.degen || !ctx_dv.first) ? '0 : tp;
			ty_s46  <= (ctx_dv.degen || ctx_dv.first) ? '0 : tp;
			tz_s46  <= ctx_dv.degen ? '0 : tq;
		end
	end

	// ---------------- stage 47: cross-product terms
	logic v_s47;
	cob_pkg::ctx_t ctx_s47;
	cob_pkg::comp_t tx_s47, ty_s47, tz_s47;
	logic signed [cob_pkg::PROD_W-1:0] y_tz_s47, z_ty_s47, z_tx_s47;
	logic signed [cob_pkg::PROD_W-1:0] x_tz_s47, x_ty_s47, y_tx_s47;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s47 <= 1'b0;
		end else if (en) begin
			v_s47 <= v_s46;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s47  <= ctx_s46;
			tx_s47   <= tx_s46;
			ty_s47   <= ty_s46;
			tz_s47   <= tz_s46;
			y_tz_s47 <= cob_pkg::PROD_W'(ctx_s46.y) * cob_pkg::PROD_W'(tz_s46);
			z_ty_s47 <= cob_pkg::PROD_W'(ctx_s46.z) * cob_pkg::PROD_W'(ty_s46);
			z_tx_s47 <= cob_pkg::PROD_W'(ctx_s46.z) * cob_pkg::PROD_W'(tx_s46);
			x_tz_s47 <= cob_pkg::PROD_W'(ctx_s46.x) * cob_pkg::PROD_W'(tz_s46);
			x_ty_s47 <= cob_pkg::PROD_W'(ctx_s46.x) * cob_pkg::PROD_W'(ty_s46);
			y_tx_s47 <= cob_pkg::PROD_W'(ctx_s46.y) * cob_pkg::PROD_W'(tx_s46);
		end
	end

	// ---------------- stage 48: differences as sign and magnitude
	logic v_s48;
	cob_pkg::ctx_t ctx_s48;
	cob_pkg::comp_t tx_s48, ty_s48, tz_s48;
	logic [cob_pkg::PROD_W-1:0] bmx_s48, bmy_s48, bmz_s48;
	logic bnx_s48, bny_s48, bnz_s48;
	logic signed [cob_pkg::DIFF_W-1:0] dfx, dfy, dfz;
	logic signed [cob_pkg::DIFF_W-1:0] ngx, ngy, ngz;

	assign dfx = {y_tz_s47[cob_pkg::PROD_W-1], y_tz_s47}
		- {z_ty_s47[cob_pkg::PROD_W-1], z_ty_s47};
	assign dfy = {z_tx_s47[cob_pkg::PROD_W-1], z_tx_s47}
		- {x_tz_s47[cob_pkg::PROD_W-1], x_tz_s47};
	assign dfz = {x_ty_s47[cob_pkg::PROD_W-1], x_ty_s47}
		- {y_tx_s47[cob_pkg::PROD_W-1], y_tx_s47};
	assign ngx = -dfx;
	assign ngy = -dfy;
	assign ngz = -dfz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s48 <= 1'b0;
		end else if (en) begin
			v_s48 <= v_s47;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s48 <= ctx_s47;
			tx_s48  <= tx_s47;
			ty_s48  <= ty_s47;
			tz_s48  <= tz_s47;
			bnx_s48 <= dfx[cob_pkg::DIFF_W-1];
			bny_s48 <= dfy[cob_pkg::DIFF_W-1];
			bnz_s48 <= dfz[cob_pkg::DIFF_W-1];
			bmx_s48 <= dfx[cob_pkg::DIFF_W-1] ? ngx[cob_pkg::PROD_W-1:0]
				: dfx[cob_pkg::PROD_W-1:0];
			bmy_s48 <= dfy[cob_pkg::DIFF_W-1] ? ngy[cob_pkg::PROD_W-1:0]
				: dfy[cob_pkg::PROD_W-1:0];
			bmz_s48 <= dfz[cob_pkg::DIFF_W-1] ? ngz[cob_pkg::PROD_W-1:0]
				: dfz[cob_pkg::PROD_W-1:0];
		end
	end

	// ---------------- stage 49: round half away from zero, saturate
	logic v_s49;
	cob_pkg::res_t res_s49;
	logic [cob_pkg::DIFF_W-1:0] rqx, rqy, rqz;

	assign rqx = ({1'b0, bmx_s48} + RND_HALF) >> FRAC_BITS;
	assign rqy = ({1'b0, bmy_s48} + RND_HALF) >> FRAC_BITS;
	assign rqz = ({1'b0, bmz_s48} + RND_HALF) >> FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s49 <= 1'b0;
		end else if (en) begin
			v_s49 <= v_s48;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s49.row0_x      <= ctx_s48.x;
			res_s49.row0_y      <= ctx_s48.y;
			res_s49.row0_z      <= ctx_s48.z;
			res_s49.tangent_a_x <= tx_s48;
			res_s49.tangent_a_y <= ty_s48;
			res_s49.tangent_a_z <= tz_s48;
			res_s49.tangent_b_x <= cob_pkg::sat_mag(rqx, bnx_s48);
			res_s49.tangent_b_y <= cob_pkg::sat_mag(rqy, bny_s48);
			res_s49.tangent_b_z <= cob_pkg::sat_mag(rqz, bnz_s48);
			res_s49.degenerate  <= ctx_s48.degen;
		end
	end

	// ---------------- skid register: park a result the sink does not take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (en) begin
			skid_valid_q <= v_s49 && !basis.ready;
		end else if (basis.ready) begin
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			skid_q <= res_s49;
		end
	end

	cob_pkg::res_t res_out;

	assign res_out = skid_valid_q ? skid_q : res_s49;

	assign basis.valid       = skid_valid_q || v_s49;
	assign basis.row0_x      = res_out.row0_x;
	assign basis.row0_y      = res_out.row0_y;
	assign basis.row0_z      = res_out.row0_z;
	assign basis.tangent_a_x = res_out.tangent_a_x;
	assign basis.tangent_a_y = res_out.tangent_a_y;
	assign basis.tangent_a_z = res_out.tangent_a_z;
	assign basis.tangent_b_x = res_out.tangent_b_x;
	assign basis.tangent_b_y = res_out.tangent_b_y;
	assign basis.tangent_b_z = res_out.tangent_b_z;
	assign basis.degenerate  = res_out.degenerate;

	// ---------------- assertions
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!nrm.ready |-> basis.valid)
		else $error("input stalled with no result waiting at the output");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		basis.valid && basis.degenerate |->
			basis.tangent_a_x == '0 && basis.tangent_a_y == '0 &&
			basis.tangent_a_z == '0 && basis.tangent_b_x == '0 &&
			basis.tangent_b_y == '0 && basis.tangent_b_z == '0)
		else $error("degenerate result carries nonzero tangents");

	a_tangent_plane: assert property (@(posedge clk) disable iff (!arst_n)
		basis.valid |-> basis.tangent_a_x == '0 || basis.tangent_a_y == '0)
		else $error("first tangent has both x and y nonzero");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !basis.ready |=> skid_valid_q && $stable(skid_q))
		else $error("parked result lost or changed while stalled");

endmodule
